### rtl/core/rmt_pkg.sv
// rmt_pkg: shared constants, codes, command and status types and helpers
// for the range max tree engine; no dependencies
package rmt_pkg;

	localparam int MAX_LEAVES = 1024;
	localparam int TREE_DEPTH = 2 * MAX_LEAVES;
	localparam int ADDR_W     = $clog2(TREE_DEPTH);
	localparam int CNT_W      = ADDR_W + 1;
	localparam int SIZE_W     = 11;
	localparam int POS_W      = 10;
	localparam int VAL_W      = 32;
	localparam int MAX_W      = 31;
	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 32;

	typedef enum logic [1:0] {
		OP_SET   = 2'd0,
		OP_QUERY = 2'd1,
		OP_BUILD = 2'd2
	} op_t;

	typedef enum logic [3:0] {
		STEP_NONE,
		STEP_CLEAR,
		STEP_SET_LEAF,
		STEP_SET_WALK,
		STEP_QUERY_INIT,
		STEP_QUERY_WALK,
		STEP_BUILD_WALK,
		STEP_BUILD_DRAIN,
		STEP_RESULT
	} dp_step_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_SET_WALK,
		ST_QUERY_WALK,
		ST_BUILD_WALK,
		ST_BUILD_DRAIN,
		ST_FINISH
	} ctrl_state_t;

	typedef struct packed {
		logic     load;
		dp_step_t step;
	} dp_cmd_t;

	typedef struct packed {
		op_t  op;
		logic set_bad;
		logic query_bad;
		logic node_gt1;
		logic parent_gt1;
		logic range_open;
		logic node_zero;
		logic clear_last;
		logic out_free;
	} dp_status_t;

	function automatic logic [VAL_W-1:0] smax(input logic [VAL_W-1:0] a,
		input logic [VAL_W-1:0] b);
		return ($signed(a) >= $signed(b)) ? a : b;
	endfunction

endpackage

### rtl/core/range_max_tree_engine.sv
// range_max_tree_engine: top level of the range max segment tree engine
// uses rmt_pkg, rmt_ctrl and rmt_datapath
//
// Bottom-up max segment tree over up to 1024 leaves held in one 2048-word
// memory with a single write port. After reset the block clears the whole
// memory, one word a cycle, and takes no item meanwhile; the size register
// may be written during that time. A set does one memory write per tree
// level, a query reads both ends of the range in parallel each level, a
// rejected item or unused code 3 goes to the result with no walk, and a
// rebuild writes one internal node per cycle. The next item is taken once
// the result is in the output register, even while that result still
// waits on m_tready.
module range_max_tree_engine (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [rmt_pkg::SIZE_W-1:0]          cfg_wr_data,   // size_in_use
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// position[9:0], leaf_value[41:10], range_low[52:42], range_high[63:53]
	input  logic [rmt_pkg::IN_DATA_W-1:0]       s_tdata,
	input  logic [1:0]                          s_tuser,       // operation[1:0]
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [rmt_pkg::OUT_DATA_W-1:0]      m_tdata,       // range_max[30:0]
	output logic                                m_tuser        // rejected[0]
);
	import rmt_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	rmt_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.status  (status),
		.cmd     (cmd)
	);

	rmt_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tuser    (s_tuser),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

endmodule

### rtl/core/rmt_ram.sv
// rmt_ram: generic memory, one write port and two registered read ports
// no dependencies
module rmt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

### rtl/core/rmt_datapath.sv
// rmt_datapath: size register, item registers, tree memory, node walk
// registers, max compare and result register; uses rmt_pkg and rmt_ram
module rmt_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rmt_pkg::dp_cmd_t                  cmd,
	output rmt_pkg::dp_status_t               status,
	input  logic                              cfg_wr_en,
	input  logic [rmt_pkg::SIZE_W-1:0]        cfg_wr_data,
	input  logic [1:0]                        s_tuser,
	input  logic [rmt_pkg::IN_DATA_W-1:0]     s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [rmt_pkg::OUT_DATA_W-1:0]    m_tdata,
	output logic                              m_tuser
);
	import rmt_pkg::*;

	logic [SIZE_W-1:0] size_q;
	logic [SIZE_W-1:0] n;
	op_t               op_q;
	logic [POS_W-1:0]  pos_q;
	logic [VAL_W-1:0]  val_q;
	logic [SIZE_W-1:0] lo_q;
	logic [SIZE_W-1:0] hi_q;
	logic [CNT_W-1:0]  node_q;
	logic [CNT_W-1:0]  edge_q;
	logic [ADDR_W-1:0] tgt_q;
	logic [VAL_W-1:0]  acc_q;
	logic              pend_a_s1;
	logic              pend_b_s1;
	logic              fwd_a_s1;
	logic              fwd_b_s1;
	logic [VAL_W-1:0]  fwd_data_s1;
	logic              m_tvalid_q;
	logic [MAX_W-1:0]  max_q;
	logic              rej_q;

	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [VAL_W-1:0]  wdata;
	logic [ADDR_W-1:0] raddr_a;
	logic [ADDR_W-1:0] raddr_b;
	logic [VAL_W-1:0]  ram_a;
	logic [VAL_W-1:0]  ram_b;
	logic [VAL_W-1:0]  rd_a;
	logic [VAL_W-1:0]  rd_b;
	logic [VAL_W-1:0]  walk_max;
	logic [VAL_W-1:0]  fold_b;
	logic [VAL_W-1:0]  fold;
	logic [CNT_W-1:0]  parent;
	logic              rejected;
	op_t               in_op;
	logic [POS_W-1:0]  in_pos;
	logic [SIZE_W-1:0] in_lo;
	logic [SIZE_W-1:0] in_hi;

	// leaves in use, clamped to the supported range
	always_comb begin
		if (size_q == '0) begin
			n = SIZE_W'(1);
		end else if (size_q > SIZE_W'(MAX_LEAVES)) begin
			n = SIZE_W'(MAX_LEAVES);
		end else begin
			n = size_q;
		end
	end

	assign in_op  = op_t'(s_tuser);
	assign in_pos = s_tdata[POS_W-1:0];
	assign in_lo  = s_tdata[POS_W+VAL_W+SIZE_W-1:POS_W+VAL_W];
	assign in_hi  = s_tdata[POS_W+VAL_W+2*SIZE_W-1:POS_W+VAL_W+SIZE_W];

	assign rd_a     = fwd_a_s1 ? fwd_data_s1 : ram_a;
	assign rd_b     = fwd_b_s1 ? fwd_data_s1 : ram_b;
	assign walk_max = smax(acc_q, rd_a);
	assign fold_b   = pend_b_s1 ? smax(acc_q, rd_b) : acc_q;
	assign fold     = pend_a_s1 ? smax(fold_b, rd_a) : fold_b;
	assign parent   = node_q >> 1;

	assign rejected = ((op_q == OP_SET) && status.set_bad) ||
		((op_q == OP_QUERY) && status.query_bad);

	always_comb begin
		status.op         = op_q;
		status.set_bad    = {1'b0, pos_q} >= n;
		status.query_bad  = (lo_q > n) || (hi_q > n);
		status.node_gt1   = node_q > CNT_W'(1);
		status.parent_gt1 = parent > CNT_W'(1);
		status.range_open = node_q < edge_q;
		status.node_zero  = node_q == '0;
		status.clear_last = node_q[ADDR_W-1:0] == '1;
		status.out_free   = !m_tvalid_q || m_tready;
	end

	// memory port selection per step
	always_comb begin
		we      = 1'b0;
		waddr   = node_q[ADDR_W-1:0];
		wdata   = '0;
		raddr_a = node_q[ADDR_W-1:0] ^ ADDR_W'(1);
		raddr_b = ADDR_W'(edge_q - CNT_W'(1));
		unique case (cmd.step) inside
			STEP_CLEAR: begin
				we = 1'b1;
			end
			STEP_SET_LEAF: begin
				we    = 1'b1;
				wdata = val_q;
			end
			STEP_SET_WALK: begin
				we      = 1'b1;
				waddr   = parent[ADDR_W-1:0];
				wdata   = walk_max;
				raddr_a = parent[ADDR_W-1:0] ^ ADDR_W'(1);
			end
			STEP_QUERY_WALK: begin
				raddr_a = node_q[ADDR_W-1:0];
			end
			STEP_BUILD_WALK, STEP_BUILD_DRAIN: begin
				we      = pend_a_s1;
				waddr   = tgt_q;
				wdata   = smax(rd_a, rd_b);
				raddr_a = {node_q[ADDR_W-2:0], 1'b0};
				raddr_b = {node_q[ADDR_W-2:0], 1'b1};
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	rmt_ram #(
		.WIDTH(VAL_W),
		.DEPTH(TREE_DEPTH)
	) u_tree_ram (
		.clk    (clk),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr_a(raddr_a),
		.raddr_b(raddr_b),
		.rdata_a(ram_a),
		.rdata_b(ram_b)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q     <= SIZE_W'(MAX_LEAVES);
			node_q     <= '0;
			pend_a_s1  <= 1'b0;
			pend_b_s1  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				size_q <= cfg_wr_data;
			end
			pend_a_s1 <= 1'b0;
			pend_b_s1 <= 1'b0;
			if (cmd.load) begin
				unique case (in_op)
					OP_SET:   node_q <= CNT_W'({1'b0, in_pos} + n);
					OP_QUERY: node_q <= CNT_W'(in_lo) + CNT_W'(n);
					default:  node_q <= CNT_W'(n - SIZE_W'(1));
				endcase
			end else begin
				case (cmd.step)
					STEP_CLEAR: begin
						node_q <= node_q + CNT_W'(1);
					end
					STEP_SET_WALK: begin
						node_q <= parent;
					end
					STEP_QUERY_WALK: begin
						if (status.range_open) begin
							pend_a_s1 <= node_q[0];
							pend_b_s1 <= edge_q[0];
							node_q    <= (node_q + CNT_W'(node_q[0])) >> 1;
						end
					end
					STEP_BUILD_WALK: begin
						if (!status.node_zero) begin
							pend_a_s1 <= 1'b1;
							node_q    <= node_q - CNT_W'(1);
						end
					end
					default: begin
						node_q <= node_q;
					end
				endcase
			end
			if (cmd.step == STEP_RESULT) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		fwd_a_s1    <= we && (waddr == raddr_a);
		fwd_b_s1    <= we && (waddr == raddr_b);
		fwd_data_s1 <= wdata;
		if (cmd.load) begin
			op_q   <= in_op;
			pos_q  <= in_pos;
			val_q  <= s_tdata[POS_W+VAL_W-1:POS_W];
			lo_q   <= in_lo;
			hi_q   <= in_hi;
			edge_q <= CNT_W'(in_hi) + CNT_W'(n);
		end
		case (cmd.step)
			STEP_SET_LEAF:   acc_q <= val_q;
			STEP_SET_WALK:   acc_q <= walk_max;
			STEP_QUERY_INIT: acc_q <= '0;
			STEP_QUERY_WALK: begin
				acc_q <= fold;
				if (status.range_open) begin
					edge_q <= edge_q >> 1;
				end
			end
			STEP_BUILD_WALK: begin
				tgt_q <= node_q[ADDR_W-1:0];
			end
			STEP_RESULT: begin
				rej_q <= rejected;
				max_q <= ((op_q == OP_QUERY) && !rejected) ? acc_q[MAX_W-1:0] : '0;
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_DATA_W'(max_q);
	assign m_tuser  = rej_q;

	a_result_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step == STEP_RESULT) |-> (!m_tvalid_q || m_tready))
		else $error("result register overwritten");

	a_build_not_root_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(we && (cmd.step == STEP_BUILD_WALK || cmd.step == STEP_BUILD_DRAIN))
		|-> (waddr != '0))
		else $error("rebuild wrote node zero");

	a_no_load_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step == STEP_CLEAR) |-> !cmd.load)
		else $error("item taken during clear");

endmodule

### rtl/core/rmt_ctrl.sv
// rmt_ctrl: sequencer for clearing, set, query and rebuild walks
// uses rmt_pkg; drives commands into rmt_datapath
module rmt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  rmt_pkg::dp_status_t status,
	output rmt_pkg::dp_cmd_t    cmd
);
	import rmt_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		cmd.load = 1'b0;
		cmd.step = STEP_NONE;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.step = STEP_CLEAR;
				if (status.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				state_d = ST_FINISH;
				case (status.op)
					OP_SET: begin
						if (!status.set_bad) begin
							cmd.step = STEP_SET_LEAF;
							if (status.node_gt1) begin
								state_d = ST_SET_WALK;
							end
						end
					end
					OP_QUERY: begin
						if (!status.query_bad) begin
							cmd.step = STEP_QUERY_INIT;
							state_d  = ST_QUERY_WALK;
						end
					end
					OP_BUILD: begin
						state_d = ST_BUILD_WALK;
					end
					default: begin
						state_d = ST_FINISH;
					end
				endcase
			end
			ST_SET_WALK: begin
				cmd.step = STEP_SET_WALK;
				if (!status.parent_gt1) begin
					state_d = ST_FINISH;
				end
			end
			ST_QUERY_WALK: begin
				cmd.step = STEP_QUERY_WALK;
				if (!status.range_open) begin
					state_d = ST_FINISH;
				end
			end
			ST_BUILD_WALK: begin
				cmd.step = STEP_BUILD_WALK;
				if (status.node_zero) begin
					state_d = ST_BUILD_DRAIN;
				end
			end
			ST_BUILD_DRAIN: begin
				cmd.step = STEP_BUILD_DRAIN;
				state_d  = ST_FINISH;
			end
			ST_FINISH: begin
				if (status.out_free) begin
					cmd.step = STEP_RESULT;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_accept_to_decode: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_DECODE))
		else $error("accepted item not decoded");

	a_set_walk_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SET_WALK)
		|-> ($past(state_q) == ST_DECODE || $past(state_q) == ST_SET_WALK))
		else $error("set walk entered from wrong state");

	a_drain_after_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BUILD_DRAIN) |-> ($past(state_q) == ST_BUILD_WALK))
		else $error("rebuild drain out of order");

endmodule

### tb/tb.sv
// tb: self-checking bench for range_max_tree_engine, set, range max query and rebuild
// keeps its own copy of the tree and the size register and checks every result in order
// depends on rmt_pkg and range_max_tree_engine
module tb;
	import rmt_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_CYCLES = 500;
	localparam int SETTLE_CYCLES = 8;
	localparam int SWEEP_ITEMS = 120;

	typedef struct packed {
		logic [MAX_W-1:0] range_max;
		logic             rejected;
	} tree_result_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [SIZE_W-1:0]     cfg_wr_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [1:0]            s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;

	logic [VAL_W-1:0]  tree_words [0:TREE_DEPTH-1];
	logic [SIZE_W-1:0] leaf_setting = SIZE_W'(1024);
	tree_result_t      results_due [$];
	tree_result_t      oldest;
	int unsigned       fail_count = 0;
	int unsigned       cycle_count = 0;
	bit                tx_steady = 1'b0;
	bit                rx_steady = 1'b0;
	bit                hold_request = 1'b0;

	logic [SIZE_W-1:0] sweep_sizes [12] = '{11'd1, 11'd2, 11'd3, 11'd7, 11'd16, 11'd33,
		11'd100, 11'd0, 11'd2047, 11'd511, 11'd1024, 11'd1025};

	range_max_tree_engine uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic int unsigned leaves_active();
		if (leaf_setting == 0)
			return 1;
		if (leaf_setting > MAX_LEAVES)
			return MAX_LEAVES;
		return 32'(leaf_setting);
	endfunction

	function automatic logic [VAL_W-1:0] signed_max(input logic [VAL_W-1:0] a,
		input logic [VAL_W-1:0] b);
		return ($signed(a) >= $signed(b)) ? a : b;
	endfunction

	task automatic predict_item(input logic [1:0] op, input logic [POS_W-1:0] pos,
		input logic [VAL_W-1:0] val, input logic [SIZE_W-1:0] lo,
		input logic [SIZE_W-1:0] hi);
		int unsigned n, p, l, r;
		logic signed [VAL_W-1:0] best;
		tree_result_t res;
		n = leaves_active();
		res = '0;
		best = '0;
		case (op)
			OP_SET: begin
				if (pos >= n) begin
					res.rejected = 1'b1;
				end else begin
					p = pos + n;
					tree_words[p] = val;
					while (p > 1) begin
						tree_words[p >> 1] = signed_max(tree_words[p], tree_words[p ^ 1]);
						p = p >> 1;
					end
				end
			end
			OP_QUERY: begin
				if (lo > n || hi > n) begin
					res.rejected = 1'b1;
				end else begin
					l = lo + n;
					r = hi + n;
					while (l < r) begin
						if (l[0]) begin
							if ($signed(tree_words[l]) > best)
								best = tree_words[l];
							l++;
						end
						if (r[0]) begin
							r--;
							if ($signed(tree_words[r]) > best)
								best = tree_words[r];
						end
						l = l >> 1;
						r = r >> 1;
					end
					res.range_max = best[MAX_W-1:0];
				end
			end
			OP_BUILD: begin
				for (int i = n - 1; i > 0; i--)
					tree_words[i] = signed_max(tree_words[2 * i], tree_words[2 * i + 1]);
			end
			default: ;
		endcase
		results_due.insert(results_due.size(), res);
	endtask

	task automatic send_item(input logic [1:0] op, input logic [POS_W-1:0] pos,
		input logic [VAL_W-1:0] val, input logic [SIZE_W-1:0] lo,
		input logic [SIZE_W-1:0] hi);
		int unsigned gap;
		gap = tx_steady ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {hi, lo, val, pos};
		do @(posedge clk); while (!s_tready);
		predict_item(op, pos, val, lo, hi);
	endtask

	task automatic send_random_item();
		int unsigned n, pick, rebuild_pct;
		logic [POS_W-1:0] pos;
		logic [VAL_W-1:0] val;
		logic [SIZE_W-1:0] lo, hi, tmp;
		n = leaves_active();
		rebuild_pct = (n > 256) ? 2 : 6;
		pick = $urandom_range(0, 99);
		pos = POS_W'($urandom_range(0, 1023));
		lo = SIZE_W'($urandom_range(0, 2047));
		hi = SIZE_W'($urandom_range(0, 2047));
		case ($urandom_range(0, 7))
			0: val = 32'h7FFF_FFFF;
			1: val = 32'h8000_0000;
			2: val = 32'h0000_0000;
			3: val = 32'hFFFF_FFFF;
			default: val = $urandom;
		endcase
		if (pick < 3) begin
			send_item(OP_UNUSED, pos, val, lo, hi);
		end else if (pick < 3 + rebuild_pct) begin
			send_item(OP_BUILD, pos, val, lo, hi);
		end else if (pick < 50) begin
			if ($urandom_range(0, 9) != 0)
				pos = POS_W'($urandom_range(0, n - 1));
			send_item(OP_SET, pos, val, lo, hi);
		end else begin
			if ($urandom_range(0, 6) != 0) begin
				lo = SIZE_W'($urandom_range(0, n));
				hi = SIZE_W'($urandom_range(lo, n));
				if ($urandom_range(0, 9) == 0) begin
					tmp = lo;
					lo = hi;
					hi = tmp;
				end
			end
			send_item(OP_QUERY, pos, val, lo, hi);
		end
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (results_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_size(input logic [SIZE_W-1:0] v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		leaf_setting = v;
	endtask

	// receiver: random stall per item, one long hold on request
	initial begin
		int unsigned stall;
		forever begin
			if (hold_request) begin
				stall = HOLD_CYCLES;
				hold_request = 1'b0;
			end else begin
				stall = rx_steady ? 0 : $urandom_range(0, 17);
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (results_due.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected item: range_max %0d rejected %0b",
						m_tdata[MAX_W-1:0], m_tuser);
			end else begin
				oldest = results_due.pop_front();
				if (m_tdata[MAX_W-1:0] !== oldest.range_max || m_tuser !== oldest.rejected) begin
					fail_count++;
					if (fail_count <= 10)
						$display("mismatch: range_max exp %0d got %0d, rejected exp %0b got %0b",
							oldest.range_max, m_tdata[MAX_W-1:0], oldest.rejected, m_tuser);
				end
			end
		end
	end

	task automatic test_full_size_edges();
		send_item(OP_QUERY, 10'd0, 32'h0, 11'd0, 11'd1024);
		send_item(OP_SET, 10'd0, 32'h7FFF_FFFF, 11'd0, 11'd0);
		send_item(OP_SET, 10'd1023, 32'h8000_0000, 11'd0, 11'd0);
		send_item(OP_QUERY, 10'd0, 32'h0, 11'd0, 11'd1024);
		send_item(OP_QUERY, 10'd0, 32'h0, 11'd1023, 11'd1024);
		send_item(OP_QUERY, 10'd0, 32'h0, 11'd5, 11'd5);
		send_item(OP_QUERY, 10'd0, 32'h0, 11'd900, 11'd3);
		send_item(OP_QUERY, 10'd0, 32'h0, 11'd1024, 11'd1024);
		send_item(OP_QUERY, 10'd0, 32'h0, 11'd0, 11'd1025);
		send_item(OP_QUERY, 10'd0, 32'h0, 11'd2047, 11'd0);
		send_item(OP_SET, 10'd1023, 32'hFFFF_FFFF, 11'd0, 11'd0);
		send_item(OP_SET, 10'd512, 32'h1234_5678, 11'd0, 11'd0);
		send_item(OP_BUILD, 10'd0, 32'h0, 11'd0, 11'd0);
		send_item(OP_QUERY, 10'd0, 32'h0, 11'd1, 11'd1023);
		send_item(OP_UNUSED, 10'h3FF, 32'hFFFF_FFFF, 11'h7FF, 11'h7FF);
		send_item(OP_QUERY, 10'h3FF, 32'hFFFF_FFFF, 11'h7FF, 11'h7FF);
	endtask

	task automatic test_small_size_bounds();
		settle();
		write_size(11'd5);
		send_item(OP_SET, 10'd5, 32'h0000_0040, 11'd0, 11'd0);
		send_item(OP_SET, 10'd4, 32'd100, 11'd0, 11'd0);
		send_item(OP_SET, 10'd0, -32'sd5, 11'd0, 11'd0);
		send_item(OP_QUERY, 10'd0, 32'h0, 11'd0, 11'd6);
		send_item(OP_QUERY, 10'd0, 32'h0, 11'd0, 11'd5);
		send_item(OP_BUILD, 10'd0, 32'h0, 11'd0, 11'd0);
		send_item(OP_QUERY, 10'd0, 32'h0, 11'd0, 11'd4);
	endtask

	task automatic test_size_sweep();
		foreach (sweep_sizes[k]) begin
			settle();
			write_size(sweep_sizes[k]);
			repeat (SWEEP_ITEMS) send_random_item();
		end
	endtask

	task automatic test_back_to_back();
		settle();
		write_size(11'd64);
		tx_steady = 1'b1;
		rx_steady = 1'b1;
		repeat (150) send_random_item();
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	task automatic test_output_stall();
		settle();
		write_size(11'd200);
		hold_request = 1'b1;
		tx_steady = 1'b1;
		repeat (50) send_random_item();
		tx_steady = 1'b0;
	endtask

	task automatic test_sender_pause();
		settle();
		write_size(11'd300);
		repeat (60) send_random_item();
		settle();
		repeat (60) send_random_item();
	endtask

	initial begin
		foreach (tree_words[i])
			tree_words[i] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		test_full_size_edges();
		test_small_size_bounds();
		test_size_sweep();
		test_back_to_back();
		test_output_stall();
		test_sender_pause();
		settle();
		repeat (40) @(posedge clk);
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule
